### sv/two_contact_key_velocity_scanner_defines.svh
// Assertion macros of the key velocity scanner top level.
// Included by the top level, which checks its own sequencing; no other dependencies.
`ifndef TWO_CONTACT_KEY_VELOCITY_SCANNER_DEFINES_SVH
`define TWO_CONTACT_KEY_VELOCITY_SCANNER_DEFINES_SVH
`ifndef SYNTHESIS
`define KVS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define KVS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define KVS_ASSERT_IMP(lbl, ante, cons, msg)
`define KVS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### sv/kvs_pkg.sv
// Types and constants of the key velocity scanner.
// Used by the register bank, the divider and the top level.
package kvs_pkg;

	localparam int TIME_W    = 32;
	localparam int LIMIT_W   = 20;
	localparam int TMO_W     = 22;
	localparam int CFG_W     = 22;
	localparam int CFG_IDX_W = 2;
	localparam int MASK_W    = 24;
	localparam int KEYNUM_W  = 5;
	localparam int VEL_W     = 7;
	localparam int DIV_N_W   = 27;
	localparam int DIV_CNT_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_TIME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIME = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd3;

	localparam logic [LIMIT_W-1:0] MIN_TIME_RST = 20'd2000;
	localparam logic [LIMIT_W-1:0] MAX_TIME_RST = 20'd50000;
	localparam logic [TMO_W-1:0]   TIMEOUT_RST  = 22'd100000;
	localparam logic [TMO_W-1:0]   DEBOUNCE_RST = 22'd5000;

	localparam logic OP_SCAN  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	localparam logic [VEL_W-1:0] VEL_FAST    = 7'd127;
	localparam logic [VEL_W-1:0] VEL_SLOW    = 7'd1;
	localparam logic [VEL_W-1:0] VEL_DEFAULT = 7'd64;

	typedef struct packed {
		logic [LIMIT_W-1:0] min_time_us;
		logic [LIMIT_W-1:0] max_time_us;
		logic [TMO_W-1:0]   timeout_us;
		logic [TMO_W-1:0]   debounce_us;
	} kvs_cfg_t;

	typedef struct packed {
		logic               start;
		logic [LIMIT_W-1:0] gap;
		logic [LIMIT_W-1:0] min_time;
		logic [LIMIT_W-1:0] max_time;
	} kvs_div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [VEL_W-1:0] quotient;
	} kvs_div_rsp_t;

endpackage

### sv/two_contact_key_velocity_scanner.sv
// Channel | direction | contents
// s_*     | in        | scan or clear-key transaction, kind in s_tuser
// m_*     | out       | one result per key, final key marked by m_tlast
// cfg_*   | in        | write-only timing limits, indices 0 to 3
//
// A clear transaction leaves the input ready. Each key of a scan is evaluated,
// classified and emitted, with the shared divider for velocities in the limits.
// The input is not ready during a scan; a held result stalls the next key.
// Reset is asynchronous and clears all key state at once.
// Top level of the key velocity scanner: key sequencer and per-key state.
// Depends on kvs_pkg, kvs_cfg_regs, kvs_div and the assertion macro header.
`include "two_contact_key_velocity_scanner_defines.svh"
module two_contact_key_velocity_scanner #(
	parameter int KEY_COUNT = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [21:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// early_mask[23:0], late_mask[47:24], now_us[79:48], reset_index[84:80], zeros
	input  logic [87:0] s_tdata,
	// operation[0]
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// key_number[4:0], pressed[5], velocity[12:6], zeros
	output logic [15:0] m_tdata,
	output logic        m_tlast
);
	import kvs_pkg::*;

	localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EVAL  = 3'd1;
	localparam logic [2:0] ST_CLASS = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	kvs_cfg_t     cfg;
	kvs_div_req_t div_req;
	kvs_div_rsp_t div_rsp;

	logic [2:0]              state_q;
	logic [KW-1:0]           key_q;
	logic [KEY_COUNT-1:0]    emask_q;
	logic [KEY_COUNT-1:0]    lmask_q;
	logic [TIME_W-1:0]       now_q;

	logic [TIME_W-1:0]       early_time_q   [KEY_COUNT];
	logic [TIME_W-1:0]       release_time_q [KEY_COUNT];
	logic [VEL_W-1:0]        key_vel_q      [KEY_COUNT];
	logic [KEY_COUNT-1:0]    early_seen_q;
	logic [KEY_COUNT-1:0]    late_seen_q;
	logic [KEY_COUNT-1:0]    vel_valid_q;
	logic [KEY_COUNT-1:0]    was_down_q;
	logic [KEY_COUNT-1:0]    is_down_q;

	logic [TIME_W-1:0]       gap_q;
	logic [TIME_W-1:0]       since_rel_q;
	logic                    need_vel_q;
	logic                    late_only_q;
	logic                    held_q;

	logic                    m_tvalid_q;
	logic [15:0]             m_tdata_q;
	logic                    m_tlast_q;

	logic                    in_acc;
	logic [KEY_COUNT-1:0]    in_emask;
	logic [KEY_COUNT-1:0]    in_lmask;
	logic [KEYNUM_W-1:0]     in_ridx;
	logic                    clr_ok;
	logic [KW-1:0]           clr_key;
	logic                    e_bit;
	logic                    l_bit;
	logic                    held;
	logic                    early_now;
	logic                    gap_ge_tmo;
	logic                    gap_lt_min;
	logic                    gap_gt_max;
	logic                    span_zero;
	logic                    div_needed;
	logic [VEL_W-1:0]        class_vel;
	logic                    out_load;
	logic                    last_key;

	kvs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	kvs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign s_tready = state_q == ST_IDLE;
	assign in_acc   = s_tvalid && s_tready;
	assign in_emask = KEY_COUNT'({8'b0, s_tdata[23:0]});
	assign in_lmask = KEY_COUNT'({8'b0, s_tdata[47:24]});
	assign in_ridx  = s_tdata[84:80];
	assign clr_ok   = {1'b0, in_ridx} < 6'(KEY_COUNT);
	assign clr_key  = in_ridx[KW-1:0];

	assign e_bit     = emask_q[key_q];
	assign l_bit     = lmask_q[key_q];
	assign held      = e_bit || l_bit;
	assign early_now = e_bit && !early_seen_q[key_q];
	assign last_key  = key_q == KW'(KEY_COUNT - 1);

	// Classification of the contact gap against the configured limits.
	assign gap_ge_tmo = gap_q >= {{(TIME_W-TMO_W){1'b0}}, cfg.timeout_us};
	assign gap_lt_min = gap_q < {{(TIME_W-LIMIT_W){1'b0}}, cfg.min_time_us};
	assign gap_gt_max = gap_q > {{(TIME_W-LIMIT_W){1'b0}}, cfg.max_time_us};
	assign span_zero  = cfg.max_time_us == cfg.min_time_us;

	always_comb begin
		div_needed = 1'b0;
		class_vel  = VEL_FAST;
		if (late_only_q) begin
			class_vel = VEL_FAST;
		end else if (gap_ge_tmo) begin
			class_vel = VEL_DEFAULT;
		end else if (gap_lt_min) begin
			class_vel = VEL_FAST;
		end else if (gap_gt_max) begin
			class_vel = VEL_SLOW;
		end else if (span_zero) begin
			class_vel = VEL_FAST;
		end else begin
			div_needed = 1'b1;
		end
	end

	assign div_req.start    = state_q == ST_CLASS && need_vel_q && div_needed;
	assign div_req.gap      = gap_q[LIMIT_W-1:0];
	assign div_req.min_time = cfg.min_time_us;
	assign div_req.max_time = cfg.max_time_us;

	assign out_load = state_q == ST_EMIT && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			key_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && s_tuser[0] == OP_SCAN) begin
						key_q   <= '0;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: state_q <= ST_CLASS;
				ST_CLASS: begin
					state_q <= div_req.start ? ST_DIV : ST_EMIT;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						if (last_key) begin
							state_q <= ST_IDLE;
						end else begin
							key_q   <= key_q + 1'b1;
							state_q <= ST_EVAL;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			emask_q <= in_emask;
			lmask_q <= in_lmask;
			now_q   <= s_tdata[79:48];
		end
		if (state_q == ST_EVAL) begin
			gap_q       <= early_now ? '0 : now_q - early_time_q[key_q];
			since_rel_q <= now_q - release_time_q[key_q];
			need_vel_q  <= l_bit && !late_seen_q[key_q];
			late_only_q <= !early_seen_q[key_q] && !e_bit;
			held_q      <= held;
		end
	end

	// Per-key state. Clears come from a clear transaction or from a release.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KEY_COUNT; k++) begin
				early_time_q[k]   <= '0;
				release_time_q[k] <= '0;
				key_vel_q[k]      <= '0;
			end
			early_seen_q <= '0;
			late_seen_q  <= '0;
			vel_valid_q  <= '0;
			was_down_q   <= '0;
			is_down_q    <= '0;
		end else begin
			if (in_acc && s_tuser[0] == OP_CLEAR && clr_ok) begin
				early_time_q[clr_key]   <= '0;
				release_time_q[clr_key] <= '0;
				key_vel_q[clr_key]      <= '0;
				early_seen_q[clr_key]   <= 1'b0;
				late_seen_q[clr_key]    <= 1'b0;
				vel_valid_q[clr_key]    <= 1'b0;
				was_down_q[clr_key]     <= 1'b0;
				is_down_q[clr_key]      <= 1'b0;
			end
			if (state_q == ST_EVAL) begin
				if (held) begin
					if (early_now) begin
						early_seen_q[key_q] <= 1'b1;
						early_time_q[key_q] <= now_q;
					end
					if (l_bit) begin
						late_seen_q[key_q] <= 1'b1;
					end
				end else if (was_down_q[key_q]) begin
					early_time_q[key_q]   <= '0;
					early_seen_q[key_q]   <= 1'b0;
					late_seen_q[key_q]    <= 1'b0;
					vel_valid_q[key_q]    <= 1'b0;
					release_time_q[key_q] <= now_q;
					is_down_q[key_q]      <= 1'b0;
				end
				was_down_q[key_q] <= held;
			end
			if (state_q == ST_CLASS) begin
				if (need_vel_q && !div_needed) begin
					key_vel_q[key_q]   <= class_vel;
					vel_valid_q[key_q] <= 1'b1;
				end
				if (held_q && !is_down_q[key_q]
						&& since_rel_q > {{(TIME_W-TMO_W){1'b0}}, cfg.debounce_us}) begin
					is_down_q[key_q] <= 1'b1;
				end
			end
			if (state_q == ST_DIV && div_rsp.done) begin
				key_vel_q[key_q]   <= VEL_FAST - div_rsp.quotient;
				vel_valid_q[key_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {3'b0,
				vel_valid_q[key_q] ? key_vel_q[key_q] : VEL_DEFAULT,
				is_down_q[key_q],
				KEYNUM_W'(key_q)};
			m_tlast_q <= last_key;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	`KVS_ASSERT_IMP(a_vel_nonzero, m_tvalid, m_tdata[12:6] != 7'd0, "velocity out of range")
	`KVS_ASSERT_IMP(a_last_key, m_tvalid && m_tlast, m_tdata[4:0] == 5'(KEY_COUNT - 1), "last flag on wrong key")
	`KVS_ASSERT_IMP(a_div_idle, s_tready, !div_rsp.busy, "divider busy while input ready")
	`KVS_ASSERT_IMP(a_quot_range, div_rsp.done, div_rsp.quotient != 7'd127 && state_q == ST_DIV, "bad quotient or stray done")
	`KVS_ASSERT_NXT(a_emit_hold, state_q == ST_EMIT && m_tvalid && !m_tready, state_q == ST_EMIT, "key skipped while output stalled")

endmodule

### sv/kvs_cfg_regs.sv
// Configuration register bank of the key velocity scanner.
// Depends on kvs_pkg for the register codes and reset values.
module kvs_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [kvs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kvs_pkg::CFG_W-1:0]        cfg_data,
	output kvs_pkg::kvs_cfg_t                cfg
);
	import kvs_pkg::*;

	kvs_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_time_us <= MIN_TIME_RST;
			cfg_q.max_time_us <= MAX_TIME_RST;
			cfg_q.timeout_us  <= TIMEOUT_RST;
			cfg_q.debounce_us <= DEBOUNCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_TIME: cfg_q.min_time_us <= cfg_data[LIMIT_W-1:0];
				CFG_MAX_TIME: cfg_q.max_time_us <= cfg_data[LIMIT_W-1:0];
				CFG_TIMEOUT:  cfg_q.timeout_us  <= cfg_data[TMO_W-1:0];
				CFG_DEBOUNCE: cfg_q.debounce_us <= cfg_data[TMO_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/kvs_div.sv
// Shared restoring divider: quotient of (gap - min) * 126 over (max - min).
// One compare and subtract per cycle, seven quotient bits. Depends on kvs_pkg.
module kvs_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kvs_pkg::kvs_div_req_t req,
	output kvs_pkg::kvs_div_rsp_t rsp
);
	import kvs_pkg::*;

	localparam logic [1:0] DV_IDLE = 2'd0;
	localparam logic [1:0] DV_MUL  = 2'd1;
	localparam logic [1:0] DV_STEP = 2'd2;

	logic [1:0]           phase_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [LIMIT_W-1:0]   offs_q;
	logic [LIMIT_W-1:0]   den_q;
	logic [DIV_N_W-1:0]   rem_q;
	logic [VEL_W-1:0]     quo_q;
	logic [DIV_N_W-1:0]   trial;
	logic                 fits;

	// The product is at most 126 spans, so the quotient always fits in seven bits.
	assign trial = {{(DIV_N_W-LIMIT_W){1'b0}}, den_q} << cnt_q;
	assign fits  = rem_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= DV_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= phase_q == DV_STEP && cnt_q == '0;
			unique case (phase_q)
				DV_IDLE: begin
					if (req.start) begin
						phase_q <= DV_MUL;
					end
				end
				DV_MUL: begin
					cnt_q   <= DIV_CNT_W'(VEL_W - 1);
					phase_q <= DV_STEP;
				end
				DV_STEP: begin
					if (cnt_q == '0) begin
						phase_q <= DV_IDLE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: phase_q <= DV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == DV_IDLE && req.start) begin
			offs_q <= req.gap - req.min_time;
			den_q  <= req.max_time - req.min_time;
		end
		if (phase_q == DV_MUL) begin
			rem_q <= {offs_q, 7'b0} - {6'b0, offs_q, 1'b0};
			quo_q <= '0;
		end
		if (phase_q == DV_STEP) begin
			if (fits) begin
				rem_q <= rem_q - trial;
			end
			quo_q <= {quo_q[VEL_W-2:0], fits};
		end
	end

	assign rsp.busy     = phase_q != DV_IDLE;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
